// ===== hdl/least_squares_loss_gradient_core_assert.svh =====
// Assertion macros shared by the loss and gradient core.
// All of them sample on the core clock and are off while reset is low.
`ifndef LEAST_SQUARES_LOSS_GRADIENT_CORE_ASSERT_SVH
`define LEAST_SQUARES_LOSS_GRADIENT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSLG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lslg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSLG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lslg assertion failed");

`endif

// ===== hdl/lslg_pkg.sv =====
`default_nettype none

package lslg_pkg;

    localparam int DIM         = 1024;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int SID_W       = 24;
    localparam int CMD_W       = 2;
    localparam int ACC_W       = 64;
    localparam int RES_W       = 49;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 96;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int DIV_CNT_W   = 6;

    localparam logic [SID_W-1:0] SID_MAX     = '1;
    localparam logic             KIND_SAMPLE = 1'b0;
    localparam logic             KIND_BATCH  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        OP_LOAD = 2'd0,
        OP_FEAT = 2'd1,
        OP_END  = 2'd2,
        OP_FIN  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic [SID_W-1:0]        sample_id;
    } t_item;

    typedef struct packed {
        logic                    empty_batch;
        logic                    overflow;
        logic [SID_W-1:0]        echo_id;
        logic [VAL_W-1:0]        mean_loss;
        logic signed [VAL_W-1:0] gradient;
        logic                    kind;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_MUL,
        BS_ACC,
        BS_RES,
        BS_MAG,
        BS_SQ,
        BS_LOSS,
        BS_FIN,
        BS_DIV,
        BS_FOUT
    } t_bstate;

endpackage

`default_nettype wire

// ===== hdl/lslg_front.sv =====
`default_nettype none

module lslg_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_tvalid,
    output logic                              o_tready,
    input  wire  [lslg_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  wire  [lslg_pkg::CMD_W-1:0]        i_tuser,
    input  wire                               i_q_full,
    output logic                              o_push,
    output lslg_pkg::t_item                   o_item
);

    logic            r_valid;
    logic            n_valid;
    lslg_pkg::t_item r_item;
    lslg_pkg::t_item n_item;
    logic            accept;

    // The holding register frees up whenever the queue takes its word.
    assign o_tready = !r_valid || !i_q_full;
    assign accept   = i_tvalid && o_tready;
    assign o_push   = r_valid && !i_q_full;
    assign o_item   = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (accept) begin
            n_valid          = 1'b1;
            n_item.op        = lslg_pkg::t_op'(i_tuser);
            n_item.index     = i_tdata[lslg_pkg::IDX_W-1:0];
            n_item.value     = i_tdata[lslg_pkg::IDX_W +: lslg_pkg::VAL_W];
            n_item.sample_id = i_tdata[lslg_pkg::IDX_W + lslg_pkg::VAL_W +: lslg_pkg::SID_W];
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ===== hdl/lslg_fifo.sv =====
`default_nettype none

module lslg_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lslg_pkg::t_item  i_item,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lslg_pkg::t_item  o_head
);

    lslg_pkg::t_item                r_buf [lslg_pkg::QUEUE_DEPTH];
    logic [lslg_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [lslg_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [lslg_pkg::QCNT_W-1:0]    r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == lslg_pkg::QCNT_W'(lslg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_buf[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lslg_div.sv =====
`default_nettype none

module lslg_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [lslg_pkg::ACC_W-1:0]       i_dividend,
    input  wire  [lslg_pkg::SID_W-1:0]       i_divisor,
    output lslg_pkg::t_div_sts               o_sts,
    output logic [lslg_pkg::ACC_W-1:0]       o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [lslg_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [lslg_pkg::SID_W-1:0]       r_rem;
    logic [lslg_pkg::SID_W-1:0]       r_dsr;
    logic [lslg_pkg::ACC_W-1:0]       r_q;
    logic [lslg_pkg::SID_W:0]         shifted;
    logic [lslg_pkg::SID_W:0]         diff;
    logic                             ge;

    // Restoring division: the dividend shifts out of the top of r_q while
    // quotient bits shift in at the bottom, one bit per cycle.
    assign shifted = {r_rem, r_q[lslg_pkg::ACC_W-1]};
    assign ge      = (shifted >= {1'b0, r_dsr});
    assign diff    = shifted - {1'b0, r_dsr};

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[lslg_pkg::SID_W-1:0] : shifted[lslg_pkg::SID_W-1:0];
            r_q   <= {r_q[lslg_pkg::ACC_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lslg_back.sv =====
`default_nettype none

`include "least_squares_loss_gradient_core_assert.svh"

module lslg_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  lslg_pkg::t_item     i_head,
    output logic                o_pop,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output lslg_pkg::t_result   o_out
);

    lslg_pkg::t_bstate                r_state;
    lslg_pkg::t_bstate                n_state;

    logic signed [lslg_pkg::VAL_W-1:0] r_wmem [lslg_pkg::DIM];
    logic signed [lslg_pkg::VAL_W-1:0] r_wrd;
    logic                              mem_we;

    logic signed [lslg_pkg::VAL_W-1:0] r_val,    n_val;
    logic [lslg_pkg::SID_W-1:0]        r_sid,    n_sid;
    logic signed [lslg_pkg::ACC_W-1:0] r_prod,   n_prod;
    logic signed [lslg_pkg::ACC_W-1:0] r_dot,    n_dot;
    logic [lslg_pkg::ACC_W-1:0]        r_loss,   n_loss;
    logic [lslg_pkg::SID_W-1:0]        r_count,  n_count;
    logic                              r_sticky, n_sticky;
    logic signed [lslg_pkg::RES_W-1:0] r_res,    n_res;
    logic signed [lslg_pkg::VAL_W-1:0] r_grad,   n_grad;
    logic [lslg_pkg::VAL_W-1:0]        r_mag,    n_mag;
    logic                              r_magbig, n_magbig;
    logic [lslg_pkg::ACC_W-1:0]        r_sq,     n_sq;
    logic                              r_ovalid, n_ovalid;
    lslg_pkg::t_result                 r_out,    n_out;

    logic                              idx_ok;
    logic                              out_free;
    logic                              sample_load;
    logic                              batch_load;
    logic                              div_start;
    lslg_pkg::t_div_sts                div_sts;
    logic [lslg_pkg::ACC_W-1:0]        div_q;

    logic signed [lslg_pkg::ACC_W-1:0] acc_sum;
    logic                              acc_ovf;
    logic [lslg_pkg::RES_W-1:0]        mag_full;
    logic                              grad_fits;
    logic [lslg_pkg::ACC_W:0]          loss_sum;
    logic                              mean_big;

    lslg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_loss),
        .i_divisor  (r_count),
        .o_sts      (div_sts),
        .o_quotient (div_q)
    );

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign out_free    = !r_ovalid || i_out_ready;
    assign idx_ok      = (32'(i_head.index) < 32'(lslg_pkg::DIM));
    assign o_pop       = (r_state == lslg_pkg::BS_IDLE) && !i_q_empty;
    assign mem_we      = o_pop && (i_head.op == lslg_pkg::OP_LOAD) && idx_ok;

    // Weight store: up to one write and one registered read per cycle at the queue head.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wmem[i_head.index] <= i_head.value;
        end
        r_wrd <= r_wmem[i_head.index];
    end

    assign acc_sum   = r_dot + r_prod;
    assign acc_ovf   = (r_dot[lslg_pkg::ACC_W-1] == r_prod[lslg_pkg::ACC_W-1]) &&
                       (acc_sum[lslg_pkg::ACC_W-1] != r_dot[lslg_pkg::ACC_W-1]);
    assign mag_full  = r_res[lslg_pkg::RES_W-1] ? (~r_res + 1'b1) : r_res;
    // Twice the residual fits 32 bits when bits 48 down to 30 all match.
    assign grad_fits = (r_res[lslg_pkg::RES_W-1:30] == '0) || (r_res[lslg_pkg::RES_W-1:30] == '1);
    assign loss_sum  = {1'b0, r_loss} + {1'b0, r_sq};
    assign mean_big  = (div_q[lslg_pkg::ACC_W-1:48] != '0);

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_sid       = r_sid;
        n_prod      = r_prod;
        n_dot       = r_dot;
        n_loss      = r_loss;
        n_count     = r_count;
        n_sticky    = r_sticky;
        n_res       = r_res;
        n_grad      = r_grad;
        n_mag       = r_mag;
        n_magbig    = r_magbig;
        n_sq        = r_sq;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_out       = r_out;
        sample_load = 1'b0;
        batch_load  = 1'b0;
        div_start   = 1'b0;

        case (r_state)
            lslg_pkg::BS_IDLE: begin
                if (o_pop) begin
                    n_val = i_head.value;
                    n_sid = i_head.sample_id;
                    case (i_head.op)
                        lslg_pkg::OP_LOAD: n_state = lslg_pkg::BS_IDLE;
                        lslg_pkg::OP_FEAT: n_state = idx_ok ? lslg_pkg::BS_MUL
                                                            : lslg_pkg::BS_IDLE;
                        lslg_pkg::OP_END:  n_state = lslg_pkg::BS_RES;
                        lslg_pkg::OP_FIN:  n_state = lslg_pkg::BS_FIN;
                        default:           n_state = lslg_pkg::BS_IDLE;
                    endcase
                end
            end
            lslg_pkg::BS_MUL: begin
                n_prod  = r_wrd * r_val;
                n_state = lslg_pkg::BS_ACC;
            end
            lslg_pkg::BS_ACC: begin
                if (acc_ovf) begin
                    n_dot    = r_prod[lslg_pkg::ACC_W-1] ? {1'b1, {(lslg_pkg::ACC_W-1){1'b0}}}
                                                         : {1'b0, {(lslg_pkg::ACC_W-1){1'b1}}};
                    n_sticky = 1'b1;
                end else begin
                    n_dot = acc_sum;
                end
                n_state = lslg_pkg::BS_IDLE;
            end
            lslg_pkg::BS_RES: begin
                n_res   = {r_dot[lslg_pkg::ACC_W-1], r_dot[lslg_pkg::ACC_W-1:16]} -
                          {{(lslg_pkg::RES_W-lslg_pkg::VAL_W){r_val[lslg_pkg::VAL_W-1]}}, r_val};
                n_state = lslg_pkg::BS_MAG;
            end
            lslg_pkg::BS_MAG: begin
                if (grad_fits) begin
                    n_grad = {r_res[30:0], 1'b0};
                end else begin
                    n_grad   = r_res[lslg_pkg::RES_W-1] ? {1'b1, {(lslg_pkg::VAL_W-1){1'b0}}}
                                                        : {1'b0, {(lslg_pkg::VAL_W-1){1'b1}}};
                    n_sticky = 1'b1;
                end
                n_mag    = mag_full[lslg_pkg::VAL_W-1:0];
                n_magbig = |mag_full[lslg_pkg::RES_W-1:lslg_pkg::VAL_W];
                if (n_magbig) begin
                    n_sticky = 1'b1;
                end
                n_state = lslg_pkg::BS_SQ;
            end
            lslg_pkg::BS_SQ: begin
                n_sq    = r_magbig ? '1 : (r_mag * r_mag);
                n_state = lslg_pkg::BS_LOSS;
            end
            lslg_pkg::BS_LOSS: begin
                if (out_free) begin
                    sample_load = 1'b1;
                    if (loss_sum[lslg_pkg::ACC_W]) begin
                        n_loss   = '1;
                        n_sticky = 1'b1;
                    end else begin
                        n_loss = loss_sum[lslg_pkg::ACC_W-1:0];
                    end
                    if (r_count == lslg_pkg::SID_MAX) begin
                        n_sticky = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                    n_dot             = '0;
                    n_ovalid          = 1'b1;
                    n_out.kind        = lslg_pkg::KIND_SAMPLE;
                    n_out.gradient    = r_grad;
                    n_out.mean_loss   = '0;
                    n_out.echo_id     = r_sid;
                    n_out.overflow    = n_sticky;
                    n_out.empty_batch = 1'b0;
                    n_state           = lslg_pkg::BS_IDLE;
                end
            end
            lslg_pkg::BS_FIN: begin
                if (r_count != '0) begin
                    div_start = 1'b1;
                    n_state   = lslg_pkg::BS_DIV;
                end else if (out_free) begin
                    batch_load        = 1'b1;
                    n_ovalid          = 1'b1;
                    n_out.kind        = lslg_pkg::KIND_BATCH;
                    n_out.gradient    = '0;
                    n_out.mean_loss   = '0;
                    n_out.echo_id     = '0;
                    n_out.overflow    = r_sticky;
                    n_out.empty_batch = 1'b1;
                    n_loss            = '0;
                    n_sticky          = 1'b0;
                    n_dot             = '0;
                    n_state           = lslg_pkg::BS_IDLE;
                end
            end
            lslg_pkg::BS_DIV: begin
                if (div_sts.done) begin
                    n_state = lslg_pkg::BS_FOUT;
                end
            end
            lslg_pkg::BS_FOUT: begin
                if (out_free) begin
                    batch_load        = 1'b1;
                    n_ovalid          = 1'b1;
                    n_out.kind        = lslg_pkg::KIND_BATCH;
                    n_out.gradient    = '0;
                    n_out.mean_loss   = mean_big ? '1 : div_q[47:16];
                    n_out.echo_id     = r_count;
                    n_out.overflow    = r_sticky || mean_big;
                    n_out.empty_batch = 1'b0;
                    n_loss            = '0;
                    n_count           = '0;
                    n_sticky          = 1'b0;
                    n_dot             = '0;
                    n_state           = lslg_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = lslg_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lslg_pkg::BS_IDLE;
            r_dot    <= '0;
            r_loss   <= '0;
            r_count  <= '0;
            r_sticky <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dot    <= n_dot;
            r_loss   <= n_loss;
            r_count  <= n_count;
            r_sticky <= n_sticky;
            r_ovalid <= n_ovalid;
        end
        r_val    <= n_val;
        r_sid    <= n_sid;
        r_prod   <= n_prod;
        r_res    <= n_res;
        r_grad   <= n_grad;
        r_mag    <= n_mag;
        r_magbig <= n_magbig;
        r_sq     <= n_sq;
        r_out    <= n_out;
    end

    `LSLG_ASSERT_IMP(a_pop_in_idle, o_pop, r_state == lslg_pkg::BS_IDLE)
    `LSLG_ASSERT_IMP(a_div_done_waited, div_sts.done, r_state == lslg_pkg::BS_DIV)
    `LSLG_ASSERT_NXT(a_batch_clears, batch_load, (r_count == '0) && (r_loss == '0) && !r_sticky)
    `LSLG_ASSERT_NXT(a_sample_clears_dot, sample_load, (r_dot == '0) && r_ovalid)

endmodule

`default_nettype wire

// ===== hdl/least_squares_loss_gradient_core.sv =====
// Channel   Direction  tdata (lowest bit first)                      tuser
// s_axis    in         index[9:0] value[41:10] sample_id[65:42]      cmd[1:0]
// m_axis    out        gradient[31:0] mean_loss[63:32] echo_id[87:64] kind[0]
//                      overflow[88] empty_batch[89]
//
// A word passes through the input register, then waits in a four-word queue.
// The back end takes one word at a time: a weight load, a feature element (weight read,
// multiply, accumulate), an end of sample, or a finish, which runs the 64-step divider
// unless the batch is empty.
// Reset is synchronous, active low, and clears sums, counter, flags and queue, not weights.
// A waiting result stalls the back end at its next result; the queue then fills up.
`default_nettype none

module least_squares_loss_gradient_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // index, value, sample_id, zero pad
    input  wire  [lslg_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // cmd
    input  wire  [lslg_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // gradient, mean_loss, echo_id, overflow, empty_batch, zero pad
    output logic [lslg_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // kind
    output logic [0:0]                         o_m_axis_tuser
);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    lslg_pkg::t_item   push_item;
    lslg_pkg::t_item   head_item;
    lslg_pkg::t_result out_word;

    lslg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (push_item)
    );

    lslg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_item)
    );

    lslg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_item),
        .o_pop       (q_pop),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (out_word)
    );

    assign o_m_axis_tdata = {6'b0, out_word.empty_batch, out_word.overflow,
                             out_word.echo_id, out_word.mean_loss, out_word.gradient};
    assign o_m_axis_tuser = out_word.kind;

endmodule

`default_nettype wire
